// ----- sv/bounded_ordered_list_engine_assert.svh -----
// Assertion macros for the ordered list engine port checker
`ifndef BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BOLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BOLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bole_pkg.sv -----
// Shared types and constants for the ordered list engine
package bole_pkg;

  localparam int BOLE_CAPACITY = 16;
  localparam int DATA_W        = 32;
  localparam int MODE_W        = 3;
  localparam int OUT_CNT_W     = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_SORTED_INS = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_REMOVE     = 3'd5,
    MODE_CONTAINS   = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_t;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic scan_clr;   // restart the position scan
    logic apply_ins;  // open a gap at the first hit and write the value
    logic apply_rem;  // close the gap at the first hit
  } cell_ctl_t;

endpackage

// ----- sv/bole_cell.sv -----
// One list cell: holds an element, ripples the first-hit scan, shifts on update
module bole_cell
  import bole_pkg::*;
#(
  parameter int CAPACITY = BOLE_CAPACITY,
  parameter int IDX      = 0
) (
  input  logic                               clk,
  input  cell_ctl_t                          ctl,
  input  mode_t                              mode,
  input  logic signed [DATA_W-1:0]           value,
  input  logic [$clog2(CAPACITY+1)-1:0]      count,
  input  logic                               prefix_in,
  input  logic signed [DATA_W-1:0]           pass_in,
  input  logic signed [DATA_W-1:0]           elem_left,
  input  logic signed [DATA_W-1:0]           elem_right,
  output logic                               prefix_out,
  output logic signed [DATA_W-1:0]           pass_out,
  output logic signed [DATA_W-1:0]           elem_out
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] IDX_C  = CW'(IDX);
  localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

  logic signed [DATA_W-1:0] elem_r, elem_nxt;
  logic                     prefix_r, prefix_nxt;
  logic signed [DATA_W-1:0] pass_r, pass_nxt;
  logic                     occ, hit, first;

  // Decide whether this cell is a candidate position for the command
  always_comb begin
    occ = (IDX_C < count);
    case (mode)
      MODE_PUSH_FRONT: hit = 1'b1;
      MODE_PUSH_BACK:  hit = !occ;
      MODE_SORTED_INS: hit = !occ || !(elem_r < value);
      MODE_POP_FRONT:  hit = occ;
      MODE_POP_BACK:   hit = (IDX_P1 == count);
      MODE_REMOVE:     hit = occ && (elem_r == value);
      MODE_CONTAINS:   hit = occ && (elem_r == value);
      MODE_CLEAR:      hit = 1'b0;
      default:         hit = 1'b0;
    endcase
  end

  // Ripple the hit prefix and the first hit's element one cell per cycle
  always_comb begin
    if (ctl.scan_clr) begin
      prefix_nxt = 1'b0;
      pass_nxt   = '0;
    end else begin
      prefix_nxt = hit || prefix_in;
      pass_nxt   = prefix_in ? pass_in : (hit ? elem_r : '0);
    end
  end

  // Shift toward the back on insert, toward the front on removal
  always_comb begin
    first    = prefix_r && !prefix_in;
    elem_nxt = elem_r;
    if (ctl.apply_ins) begin
      if (first) begin
        elem_nxt = value;
      end else if (prefix_r) begin
        elem_nxt = elem_left;
      end
    end else if (ctl.apply_rem && prefix_r) begin
      elem_nxt = elem_right;
    end
  end

  always_ff @(posedge clk) begin
    elem_r   <= elem_nxt;
    prefix_r <= prefix_nxt;
    pass_r   <= pass_nxt;
  end

  assign prefix_out = prefix_r;
  assign pass_out   = pass_r;
  assign elem_out   = elem_r;

endmodule

// ----- sv/bounded_ordered_list_engine.sv -----
// An accepted command is held while the first-hit scan ripples one cell per
// cycle through the CAPACITY-long cell chain; the list update and the result
// then load together, and only one command is in flight at a time.
// The input stalls from acceptance until the result is loaded; a pending
// result may be stalled while the next command is taken.
// Reset (rst_n low, synchronous) empties the list and drops any result.
module bounded_ordered_list_engine
  import bole_pkg::*;
#(
  parameter int CAPACITY = BOLE_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [MODE_W-1:0]           in_mode,
  input  logic signed [DATA_W-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic signed [DATA_W-1:0]    out_value_out,
  output logic [OUT_CNT_W-1:0]        out_count,
  output logic                        out_empty_res
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] SCAN_LAST = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  mode_t                    mode_r;
  logic signed [DATA_W-1:0] value_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ok_r, ok_nxt;
  logic signed [DATA_W-1:0] out_value_r, vout_nxt;
  logic [OUT_CNT_W-1:0]     out_count_r;
  logic                     out_empty_r;

  logic                     accept, apply, is_ins, is_rem, ins_ok, found;
  cell_ctl_t                ctl;

  logic                     pre_w  [CAPACITY+1];
  logic signed [DATA_W-1:0] pass_w [CAPACITY+1];
  logic signed [DATA_W-1:0] elem_w [CAPACITY+2];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign apply    = (state_r == ST_SCAN) && (scan_cnt_r == SCAN_LAST) &&
                    !(out_valid_r && out_stall);

  // Classify the held command
  assign is_ins = (mode_r == MODE_PUSH_FRONT) || (mode_r == MODE_PUSH_BACK) ||
                  (mode_r == MODE_SORTED_INS);
  assign is_rem = (mode_r == MODE_POP_FRONT) || (mode_r == MODE_POP_BACK) ||
                  (mode_r == MODE_REMOVE);
  assign ins_ok = (count_r < CAP_C);
  assign found  = pre_w[CAPACITY];

  assign ctl.scan_clr  = accept;
  assign ctl.apply_ins = apply && is_ins && ins_ok;
  assign ctl.apply_rem = apply && is_rem && found;

  // Chain ends
  assign pre_w[0]           = 1'b0;
  assign pass_w[0]          = '0;
  assign elem_w[0]          = '0;
  assign elem_w[CAPACITY+1] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bole_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .mode       (mode_r),
      .value      (value_r),
      .count      (count_r),
      .prefix_in  (pre_w[i]),
      .pass_in    (pass_w[i]),
      .elem_left  (elem_w[i]),
      .elem_right (elem_w[i+2]),
      .prefix_out (pre_w[i+1]),
      .pass_out   (pass_w[i+1]),
      .elem_out   (elem_w[i+1])
    );
  end

  // Sequence the scan and form the result
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    count_nxt    = count_r;
    ok_nxt       = 1'b0;
    vout_nxt     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r != SCAN_LAST) begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
        if (apply) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (is_ins) begin
      ok_nxt = ins_ok;
      if (ins_ok) begin
        count_nxt = count_r + 1'b1;
      end
    end else if (is_rem) begin
      ok_nxt = found;
      if (found) begin
        vout_nxt  = pass_w[CAPACITY];
        count_nxt = count_r - 1'b1;
      end
    end else if (mode_r == MODE_CONTAINS) begin
      ok_nxt = found;
    end else begin
      ok_nxt    = 1'b1;
      count_nxt = '0;
    end
  end

  // Hold the result until taken
  always_comb begin
    if (apply) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (apply) begin
        count_r <= count_nxt;
      end
    end
  end

  // Capture the command and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= mode_t'(in_mode);
      value_r <= in_value;
    end
    if (apply) begin
      out_ok_r    <= ok_nxt;
      out_value_r <= vout_nxt;
      out_count_r <= OUT_CNT_W'(count_nxt);
      out_empty_r <= (count_nxt == '0);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_value_out = out_value_r;
  assign out_count     = out_count_r;
  assign out_empty_res = out_empty_r;

endmodule

// ----- sv/bole_chk.sv -----
// Port checker for the ordered list engine, bound to the top level
`include "bounded_ordered_list_engine_assert.svh"

module bole_chk
  import bole_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_ok,
  input logic signed [DATA_W-1:0] out_value_out,
  input logic [OUT_CNT_W-1:0]     out_count,
  input logic                     out_empty_res
);

  // One command in flight: an accepted transaction blocks the next one
  `BOLE_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second command taken while busy")

  // An empty list reports a zero count
  `BOLE_ASSERT_NOW(a_empty_count, out_valid && out_empty_res, out_count == '0, "empty with nonzero count")

  // A failed command never hands back an element
  `BOLE_ASSERT_NOW(a_fail_zero, out_valid && !out_ok, out_value_out == '0, "failed command returned a value")

  // Hold a stalled result
  `BOLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_ok) && $stable(out_value_out) && $stable(out_count) && $stable(out_empty_res), "stalled result changed")

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ok        (out_ok),
  .out_value_out (out_value_out),
  .out_count     (out_count),
  .out_empty_res (out_empty_res)
);

// ----- test/ordered_list_checker.sv -----
// Checker for the ordered list engine: predicts each command's result and scores the output
`timescale 1ns / 100ps

module ordered_list_checker
  import bole_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     out_ok,
  input  logic signed [DATA_W-1:0] out_value_out,
  input  logic [OUT_CNT_W-1:0]     out_count,
  input  logic                     out_empty_res,
  output int                       fail_count,
  output int                       awaited_count
);

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] removed;
    logic [OUT_CNT_W-1:0]     count;
    logic                     empty;
  } list_result_t;

  // Mirror of the list contents, front at index 0
  logic signed [DATA_W-1:0] held_vals [BOLE_CAPACITY];
  int                       held_len = 0;
  list_result_t             awaited_results [$];
  int                       fail_tally = 0;

  // Pull one element out of the mirror and close the gap behind it
  function automatic logic signed [DATA_W-1:0] take_at(int pos);
    logic signed [DATA_W-1:0] v;
    int k;
    v = held_vals[pos];
    for (k = pos; k < held_len - 1; k++) held_vals[k] = held_vals[k + 1];
    held_len--;
    return v;
  endfunction

  // Index of the first equal element, or held_len when absent
  function automatic int find_first(logic signed [DATA_W-1:0] v);
    int k;
    for (k = 0; k < held_len; k++) if (held_vals[k] == v) return k;
    return held_len;
  endfunction

  // Apply one command to the mirror and return the result it should produce
  function automatic list_result_t apply_list_cmd(mode_t op, logic signed [DATA_W-1:0] v);
    list_result_t r;
    int pos;
    int k;
    r = '0;
    case (op)
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_SORTED_INS: begin
        if (held_len < BOLE_CAPACITY) begin
          if (op == MODE_PUSH_FRONT) begin
            pos = 0;
          end else if (op == MODE_PUSH_BACK) begin
            pos = held_len;
          end else begin
            // go in before the first element not less than the value
            pos = 0;
            while (pos < held_len && held_vals[pos] < v) pos++;
          end
          for (k = held_len; k > pos; k--) held_vals[k] = held_vals[k - 1];
          held_vals[pos] = v;
          held_len++;
          r.ok = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (held_len > 0) begin
          r.removed = take_at(0);
          r.ok      = 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (held_len > 0) begin
          r.removed = take_at(held_len - 1);
          r.ok      = 1'b1;
        end
      end
      MODE_REMOVE: begin
        pos = find_first(v);
        if (pos < held_len) begin
          r.removed = take_at(pos);
          r.ok      = 1'b1;
        end
      end
      MODE_CONTAINS: begin
        r.ok = (find_first(v) < held_len);
      end
      default: begin
        held_len = 0;
        r.ok     = 1'b1;
      end
    endcase
    r.count = held_len[OUT_CNT_W-1:0];
    r.empty = (held_len == 0);
    return r;
  endfunction

  task automatic report_field(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      fail_tally++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Predict on each input transaction, score each result transaction
  always @(posedge clk) begin : watch_channels
    list_result_t want;
    if (!rst_n) begin
      held_len = 0;
      awaited_results.delete();
    end else begin
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_list_cmd(mode_t'(in_mode), in_value));
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected result, expected none, actual ok=%0d value=%0d count=%0d",
                   $time, out_ok, out_value_out, out_count);
        end else begin
          want = awaited_results.pop_front();
          report_field("ok", want.ok, out_ok);
          report_field("value_out", want.removed, out_value_out);
          report_field("count", want.count, out_count);
          report_field("empty_res", want.empty, out_empty_res);
        end
      end
    end
    fail_count    <= fail_tally;
    awaited_count <= awaited_results.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the ordered list engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import bole_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT    = 9;
  localparam int PHASE_ITEMS    = 150;
  localparam int POOL_SIZE      = 6;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  logic [MODE_W-1:0]        in_mode   = MODE_CLEAR;
  logic signed [DATA_W-1:0] in_value  = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_value_out;
  logic [OUT_CNT_W-1:0]     out_count;
  logic                     out_empty_res;

  int fail_count;
  int awaited_count;

  int                       idle_cycles  = 0;
  int                       stall_window = 0;
  logic [1:0]               stall_style  = '0;
  int                       burst_left   = 0;
  int                       gap_len;
  int                       phase;
  int                       n;
  logic signed [DATA_W-1:0] value_pool [POOL_SIZE];

  always #5 clk = ~clk;

  bounded_ordered_list_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_value_out (out_value_out),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

  ordered_list_checker checker_inst (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_value_out (out_value_out),
    .out_count     (out_count),
    .out_empty_res (out_empty_res),
    .fail_count    (fail_count),
    .awaited_count (awaited_count)
  );

  // Stall the result channel in windows of changing style
  always @(posedge clk) begin
    if (stall_window == 0) begin
      stall_style  <= 2'($urandom_range(0, 3));
      stall_window <= $urandom_range(16, 200);
    end else begin
      stall_window <= stall_window - 1;
    end
    case (stall_style)
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_window[2];
    endcase
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Present one command and hold it until the engine takes it
  task automatic send_cmd(input mode_t op, input logic signed [DATA_W-1:0] v);
    in_valid <= 1'b1;
    in_mode  <= op;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid between bursts
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_len    = $urandom_range(0, 24);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Hold off until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic mode_t pick_mode(int kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      0: begin
        // fill: mostly inserts so the list runs full
        if (r < 70) return mode_t'($urandom_range(0, 2));
        if (r < 90) return mode_t'($urandom_range(3, 5));
        if (r < 98) return MODE_CONTAINS;
        return MODE_CLEAR;
      end
      1: begin
        // drain: mostly removals so the list runs empty
        if (r < 25) return mode_t'($urandom_range(0, 2));
        if (r < 85) return mode_t'($urandom_range(3, 5));
        if (r < 98) return MODE_CONTAINS;
        return MODE_CLEAR;
      end
      default: begin
        if (r < 97) return mode_t'($urandom_range(0, 6));
        return MODE_CLEAR;
      end
    endcase
  endfunction

  // Favor pool values so removes and lookups hit, with duplicates
  function automatic logic signed [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 85) return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: removals and lookups on an empty list
    send_cmd(MODE_POP_FRONT, 32'sd7);
    send_cmd(MODE_POP_BACK, 32'sd7);
    send_cmd(MODE_REMOVE, 32'sd5);
    send_cmd(MODE_CONTAINS, 32'sd5);
    send_cmd(MODE_CLEAR, 32'sd0);
    // extremes at both ends, then sorted inserts with a duplicate
    send_cmd(MODE_PUSH_FRONT, 32'sh8000_0000);
    send_cmd(MODE_PUSH_BACK, 32'sh7fff_ffff);
    send_cmd(MODE_SORTED_INS, -32'sd1);
    send_cmd(MODE_SORTED_INS, 32'sd0);
    send_cmd(MODE_SORTED_INS, 32'sd0);
    send_cmd(MODE_SORTED_INS, 32'sh7fff_ffff);
    send_cmd(MODE_SORTED_INS, 32'sh8000_0000);
    send_cmd(MODE_CONTAINS, 32'sd0);
    send_cmd(MODE_CONTAINS, 32'sd1);
    send_cmd(MODE_REMOVE, 32'sd0);
    send_cmd(MODE_REMOVE, 32'sd12345);
    send_cmd(MODE_POP_FRONT, 32'sd0);
    send_cmd(MODE_POP_BACK, -32'sd1);
    send_cmd(MODE_CLEAR, 32'sh5a5a_a5a5);
    send_cmd(MODE_POP_BACK, 32'sd0);
    drain_results();

    // Random phases rotating between fill, drain and mixed traffic
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      for (n = 0; n < POOL_SIZE; n++)
        value_pool[n] = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 20) - 10 : $urandom;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pace_sender();
        send_cmd(pick_mode(phase % 3), pick_value());
      end
      drain_results();
    end

    repeat (3 * BOLE_CAPACITY) @(posedge clk);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
